### hdl/psff_pkg.sv
package psff_pkg;

  localparam int MAX_PROCS    = 32;
  localparam int MAX_SEGMENTS = 64;
  localparam int MAX_DEVICES  = 8;
  localparam int LEVELS       = 5;
  localparam int QUEUES       = LEVELS + 2 * MAX_DEVICES;

  localparam int SLOT_W = $clog2(MAX_PROCS);
  localparam int SEG_AW = $clog2(MAX_SEGMENTS);
  localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
  localparam int Q_W    = $clog2(QUEUES);
  localparam int DLIM_W = $clog2(MAX_DEVICES + 1) + 1;

  localparam logic [31:0] MEM_BYTES_RESET = 32'd65536;
  localparam logic [3:0]  DEV_COUNT_RESET = 4'd1;

  // command codes
  localparam logic [2:0] OP_ARRIVE   = 3'd0;
  localparam logic [2:0] OP_TERM     = 3'd1;
  localparam logic [2:0] OP_REQ_DISK = 3'd2;
  localparam logic [2:0] OP_REQ_PRN  = 3'd3;
  localparam logic [2:0] OP_FIN_DISK = 3'd4;
  localparam logic [2:0] OP_FIN_PRN  = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_DEV  = 3'd1;
  localparam logic [2:0] ST_CPU_IDLE = 3'd2;
  localparam logic [2:0] ST_NO_MEM   = 3'd3;
  localparam logic [2:0] ST_BAD_PRIO = 3'd4;
  localparam logic [2:0] ST_Q_EMPTY  = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  // register indexes
  localparam logic [1:0] CFG_MEM_BYTES = 2'd0;
  localparam logic [1:0] CFG_PRINTERS  = 2'd1;
  localparam logic [1:0] CFG_DISKS     = 2'd2;

  typedef enum logic [4:0] {
    DC_NOP,
    DC_LOAD,
    DC_FAIL,
    DC_ARR_INIT,
    DC_SEG_RD,
    DC_SCAN_NEXT,
    DC_FOUND,
    DC_SHIFT_RD,
    DC_SHIFT_WR,
    DC_SPLIT_WR,
    DC_ALLOC_WR,
    DC_PUSH_LVL,
    DC_PUSH_DEV,
    DC_PICK,
    DC_TAKE_RUN,
    DC_PULL_DEV,
    DC_M_HOLD,
    DC_M_STEP,
    DC_M_END,
    DC_TERM_PICK,
    DC_RESULT
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t    cmd;
    logic [2:0] code;
  } psff_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       prio_bad;
    logic       dev_bad;
    logic       busy;
    logic       devq_ne;
    logic       slot_full;
    logic       scan_end;
    logic       fit;
    logic       split;
    logic       seg_full;
    logic       shift_more;
    logic       out_free;
  } psff_stat_t;

endpackage

### hdl/psff_ctrl.sv
module psff_ctrl import psff_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  psff_stat_t stat,
  output psff_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_SCAN_CHK,
    S_SHIFT,
    S_SHIFT_WR,
    S_ALLOC,
    S_PUSH_LVL,
    S_PICK_IF,
    S_M_HOLD,
    S_M_LOOP,
    S_M_STEP,
    S_RQ_PICK,
    S_RQ_PUSH,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '{cmd: DC_NOP, code: ST_OK};
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cmd   = DC_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_OUT;
        case (stat.op)
          OP_ARRIVE: begin
            if (stat.prio_bad) begin
              cmd = '{cmd: DC_FAIL, code: ST_BAD_PRIO};
            end else begin
              cmd.cmd = DC_ARR_INIT;  // flags table full itself
              if (!stat.slot_full) state_nxt = S_SCAN;
            end
          end
          OP_TERM: begin
            if (!stat.busy) begin
              cmd = '{cmd: DC_FAIL, code: ST_CPU_IDLE};
            end else begin
              cmd.cmd   = DC_TAKE_RUN;
              state_nxt = S_M_HOLD;
            end
          end
          OP_REQ_DISK, OP_REQ_PRN: begin
            if (stat.dev_bad) begin
              cmd = '{cmd: DC_FAIL, code: ST_BAD_DEV};
            end else if (!stat.busy) begin
              cmd = '{cmd: DC_FAIL, code: ST_CPU_IDLE};
            end else begin
              cmd.cmd   = DC_TAKE_RUN;
              state_nxt = S_RQ_PICK;
            end
          end
          OP_FIN_DISK, OP_FIN_PRN: begin
            if (stat.dev_bad) begin
              cmd = '{cmd: DC_FAIL, code: ST_BAD_DEV};
            end else if (!stat.devq_ne) begin
              cmd = '{cmd: DC_FAIL, code: ST_Q_EMPTY};
            end else begin
              cmd.cmd   = DC_PULL_DEV;
              state_nxt = S_PUSH_LVL;
            end
          end
          default: cmd = '{cmd: DC_FAIL, code: ST_BAD_DEV};
        endcase
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          cmd       = '{cmd: DC_FAIL, code: ST_NO_MEM};
          state_nxt = S_OUT;
        end else begin
          cmd.cmd   = DC_SEG_RD;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (!stat.fit) begin
          cmd.cmd   = DC_SCAN_NEXT;
          state_nxt = S_SCAN;
        end else if (stat.split && stat.seg_full) begin
          cmd       = '{cmd: DC_FAIL, code: ST_FULL};
          state_nxt = S_OUT;
        end else begin
          cmd.cmd   = DC_FOUND;
          state_nxt = stat.split ? S_SHIFT : S_ALLOC;
        end
      end
      S_SHIFT: begin
        if (stat.shift_more) begin
          cmd.cmd   = DC_SHIFT_RD;
          state_nxt = S_SHIFT_WR;
        end else begin
          cmd.cmd   = DC_SPLIT_WR;
          state_nxt = S_ALLOC;
        end
      end
      S_SHIFT_WR: begin
        cmd.cmd   = DC_SHIFT_WR;
        state_nxt = S_SHIFT;
      end
      S_ALLOC: begin
        cmd.cmd   = DC_ALLOC_WR;
        state_nxt = S_PUSH_LVL;
      end
      S_PUSH_LVL: begin
        cmd.cmd   = DC_PUSH_LVL;
        state_nxt = S_PICK_IF;
      end
      S_PICK_IF: begin
        if (!stat.busy) cmd.cmd = DC_PICK;
        state_nxt = S_OUT;
      end
      S_M_HOLD: begin
        cmd.cmd   = DC_M_HOLD;
        state_nxt = S_M_LOOP;
      end
      S_M_LOOP: begin
        if (stat.scan_end) begin
          cmd.cmd   = DC_M_END;
          state_nxt = S_PICK_IF;  // cpu is still marked busy here
        end else begin
          cmd.cmd   = DC_SEG_RD;
          state_nxt = S_M_STEP;
        end
      end
      S_M_STEP: begin
        cmd.cmd   = DC_M_STEP;
        state_nxt = S_M_LOOP;
      end
      // a device request reschedules before queueing the old process
      S_RQ_PICK: begin
        cmd.cmd   = DC_PICK;
        state_nxt = S_RQ_PUSH;
      end
      S_RQ_PUSH: begin
        cmd.cmd   = DC_PUSH_DEV;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.cmd   = DC_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // terminate frees its slot and reschedules in one go
    if (state_r == S_PICK_IF && stat.op == OP_TERM) cmd.cmd = DC_TERM_PICK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/psff_dp.sv
module psff_dp import psff_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  psff_cmd_t   cmd,
  output psff_stat_t  stat,
  input  logic [2:0]  in_op,
  input  logic [2:0]  in_priority_req,
  input  logic [31:0] in_req_size,
  input  logic [2:0]  in_device,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [2:0]  out_status,
  output logic [15:0] out_pid,
  output logic [15:0] out_running_pid,
  output logic [31:0] out_alloc_start
);

  // latched transaction
  logic [2:0]  op_r, prio_r, dev_r, status_r;
  logic [31:0] size_r, start_r;
  logic [15:0] pid_out_r;

  logic [31:0] mem_bytes_r;
  logic [3:0]  prn_cnt_r, disk_cnt_r;

  // scheduler state
  logic [15:0]       pid_cnt_r;
  logic              busy_r;
  logic [SLOT_W-1:0] run_r, s_r, slot_r;
  logic [MAX_PROCS-1:0] pvalid_r;
  logic [15:0]       ppid   [MAX_PROCS];
  logic [2:0]        plevel [MAX_PROCS];
  logic [SLOT_W-1:0] plink  [MAX_PROCS];
  logic [SLOT_W-1:0] qhead  [QUEUES];
  logic [SLOT_W-1:0] qtail  [QUEUES];
  logic [QUEUES-1:0] qne_r;

  // segment table
  logic [31:0] seg_start_m [MAX_SEGMENTS];
  logic [31:0] seg_size_m  [MAX_SEGMENTS];
  logic [15:0] seg_owner_m [MAX_SEGMENTS];
  logic [31:0] rd_start_r, rd_size_r;
  logic [15:0] rd_owner_r;
  logic        rd_def_r, e0def_r;
  logic [SEG_CW-1:0] count_r, idx_r, j_r, seg_r, w_r;
  logic [31:0] fstart_r, fsize_r, h_start_r, h_size_r;
  logic [15:0] h_owner_r;
  logic        out_valid_r;

  logic [31:0] r_start, r_size;
  logic [15:0] r_owner, r_owner_c;
  logic        printer;
  logic [Q_W-1:0] devq, qa, pick_lv;
  logic        any_lvl;
  logic [SLOT_W-1:0] head_q, tail_q, link_h, pa, slot_free;
  logic        slot_full;
  logic [3:0]  dev_reg;
  logic [DLIM_W-1:0] dev_lim;
  logic [15:0] pid_inc, pid_rd;
  logic        push_en, pull_en, seg_we, seg_re;
  logic [SEG_AW-1:0] wa, ra;
  logic [31:0] w_start, w_size;
  logic [15:0] w_owner;
  logic        h_merge;

  // entry 0 reads as the loaded free segment until first written
  assign r_start   = rd_def_r ? '0 : rd_start_r;
  assign r_size    = rd_def_r ? mem_bytes_r : rd_size_r;
  assign r_owner   = rd_def_r ? '0 : rd_owner_r;
  assign r_owner_c = (r_owner == pid_out_r) ? '0 : r_owner;
  assign h_merge   = (h_owner_r == '0) && (r_owner_c == '0);

  assign printer = (op_r == OP_REQ_PRN) || (op_r == OP_FIN_PRN);
  assign devq    = Q_W'(LEVELS) + (printer ? Q_W'(MAX_DEVICES) : '0) + Q_W'(dev_r);
  assign dev_reg = printer ? prn_cnt_r : disk_cnt_r;
  assign dev_lim = (DLIM_W'(dev_reg) > DLIM_W'(MAX_DEVICES)) ? DLIM_W'(MAX_DEVICES)
                                                             : DLIM_W'(dev_reg);

  assign pid_inc = (pid_cnt_r == 16'hFFFF) ? 16'd1 : pid_cnt_r + 16'd1;

  always_comb begin
    slot_free = '0;
    slot_full = 1'b1;
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      if (!pvalid_r[i]) begin
        slot_free = SLOT_W'(i);
        slot_full = 1'b0;
      end
    end
  end

  always_comb begin
    pick_lv = '0;
    any_lvl = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      if (qne_r[i]) begin
        pick_lv = Q_W'(i);
        any_lvl = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (cmd.cmd)
      DC_PUSH_LVL:                   qa = Q_W'(plevel[s_r]);
      DC_PUSH_DEV, DC_PULL_DEV:      qa = devq;
      default:                       qa = pick_lv;
    endcase
  end

  assign head_q = qhead[qa];
  assign tail_q = qtail[qa];
  assign link_h = plink[head_q];
  assign pa     = (cmd.cmd == DC_PULL_DEV) ? head_q : run_r;
  assign pid_rd = ppid[pa];

  assign push_en = (cmd.cmd == DC_PUSH_LVL) || (cmd.cmd == DC_PUSH_DEV);
  assign pull_en = (cmd.cmd == DC_PULL_DEV) ||
                   (((cmd.cmd == DC_PICK) || (cmd.cmd == DC_TERM_PICK)) && any_lvl);

  always_comb begin
    seg_we  = 1'b0;
    seg_re  = 1'b0;
    wa      = w_r[SEG_AW-1:0];
    ra      = idx_r[SEG_AW-1:0];
    w_start = h_start_r;
    w_size  = h_size_r;
    w_owner = h_owner_r;
    unique case (cmd.cmd)
      DC_SEG_RD:   seg_re = 1'b1;
      // first entry for the merge pass
      DC_TAKE_RUN: begin
        seg_re = 1'b1;
        ra     = '0;
      end
      DC_SHIFT_RD: begin
        seg_re = 1'b1;
        ra     = j_r[SEG_AW-1:0];
      end
      DC_SHIFT_WR: begin
        seg_we  = 1'b1;
        wa      = SEG_AW'(j_r + SEG_CW'(1));
        w_start = r_start;
        w_size  = r_size;
        w_owner = r_owner;
      end
      DC_SPLIT_WR: begin
        seg_we  = 1'b1;
        wa      = SEG_AW'(seg_r + SEG_CW'(1));
        w_start = fstart_r + size_r;
        w_size  = fsize_r - size_r;
        w_owner = '0;
      end
      DC_ALLOC_WR: begin
        seg_we  = 1'b1;
        wa      = seg_r[SEG_AW-1:0];
        w_start = fstart_r;
        w_size  = size_r;
        w_owner = pid_cnt_r;
      end
      DC_M_STEP: seg_we = !h_merge;
      DC_M_END:  seg_we = 1'b1;
      default: ;
    endcase
  end

  assign stat.op         = op_r;
  assign stat.prio_bad   = {1'b0, prio_r} >= 4'(LEVELS);
  assign stat.dev_bad    = DLIM_W'(dev_r) >= dev_lim;
  assign stat.busy       = busy_r;
  assign stat.devq_ne    = qne_r[devq];
  assign stat.slot_full  = slot_full;
  assign stat.scan_end   = (idx_r == count_r);
  assign stat.fit        = (r_owner == '0) && (r_size >= size_r);
  assign stat.split      = r_size > size_r;
  assign stat.seg_full   = count_r >= SEG_CW'(MAX_SEGMENTS);
  assign stat.shift_more = j_r > seg_r;
  assign stat.out_free   = !out_valid_r || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_bytes_r <= MEM_BYTES_RESET;
      prn_cnt_r   <= DEV_COUNT_RESET;
      disk_cnt_r  <= DEV_COUNT_RESET;
      pid_cnt_r   <= '0;
      busy_r      <= 1'b0;
      run_r       <= '0;
      pvalid_r    <= '0;
      qne_r       <= '0;
      count_r     <= SEG_CW'(1);
      e0def_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cmd == DC_ARR_INIT) pid_cnt_r <= pid_inc;
      if (cmd.cmd == DC_ALLOC_WR) pvalid_r[slot_r] <= 1'b1;
      if (cmd.cmd == DC_TERM_PICK) pvalid_r[s_r] <= 1'b0;
      if ((cmd.cmd == DC_PICK) || (cmd.cmd == DC_TERM_PICK)) begin
        busy_r <= any_lvl;
        run_r  <= any_lvl ? head_q : '0;
      end
      if (push_en) qne_r[qa] <= 1'b1;
      if (pull_en && (head_q == tail_q)) qne_r[qa] <= 1'b0;
      if (cmd.cmd == DC_SPLIT_WR) count_r <= count_r + SEG_CW'(1);
      if (cmd.cmd == DC_M_END) count_r <= w_r + SEG_CW'(1);
      if (seg_we && (wa == '0)) e0def_r <= 1'b0;
      if (cmd.cmd == DC_RESULT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MEM_BYTES: begin
            mem_bytes_r <= cfg_data;
            count_r     <= SEG_CW'(1);
            e0def_r     <= 1'b1;
          end
          CFG_PRINTERS: prn_cnt_r  <= cfg_data[3:0];
          CFG_DISKS:    disk_cnt_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (cmd.cmd)
      DC_LOAD: begin
        op_r      <= in_op;
        prio_r    <= in_priority_req;
        size_r    <= in_req_size;
        dev_r     <= in_device;
        status_r  <= ST_OK;
        pid_out_r <= '0;
        start_r   <= '0;
      end
      DC_FAIL: status_r <= cmd.code;
      DC_ARR_INIT: begin
        slot_r <= slot_free;
        idx_r  <= '0;
        if (slot_full) status_r <= ST_FULL;
      end
      DC_SCAN_NEXT: idx_r <= idx_r + SEG_CW'(1);
      DC_FOUND: begin
        seg_r    <= idx_r;
        fstart_r <= r_start;
        fsize_r  <= r_size;
        j_r      <= count_r - SEG_CW'(1);
      end
      DC_SHIFT_WR: j_r <= j_r - SEG_CW'(1);
      DC_ALLOC_WR: begin
        start_r        <= fstart_r;
        pid_out_r      <= pid_cnt_r;
        s_r            <= slot_r;
        ppid[slot_r]   <= pid_cnt_r;
        plevel[slot_r] <= prio_r;
        plink[slot_r]  <= '0;
      end
      DC_TAKE_RUN: begin
        s_r       <= run_r;
        pid_out_r <= pid_rd;
        idx_r     <= '0;
      end
      DC_PULL_DEV: begin
        s_r       <= head_q;
        pid_out_r <= pid_rd;
      end
      DC_M_HOLD: begin
        h_start_r <= r_start;
        h_size_r  <= r_size;
        h_owner_r <= r_owner_c;
        w_r       <= '0;
        idx_r     <= SEG_CW'(1);
      end
      DC_M_STEP: begin
        idx_r <= idx_r + SEG_CW'(1);
        if (h_merge) begin
          h_size_r <= h_size_r + r_size;
        end else begin
          w_r       <= w_r + SEG_CW'(1);
          h_start_r <= r_start;
          h_size_r  <= r_size;
          h_owner_r <= r_owner_c;
        end
      end
      DC_RESULT: begin
        out_ok          <= (status_r == ST_OK);
        out_status      <= status_r;
        out_pid         <= pid_out_r;
        out_running_pid <= busy_r ? pid_rd : '0;
        out_alloc_start <= start_r;
      end
      default: ;
    endcase
    if (cmd.cmd == DC_SEG_RD) idx_r <= idx_r;
    if (push_en) begin
      if (qne_r[qa]) begin
        plink[tail_q] <= s_r;
      end else begin
        qhead[qa] <= s_r;
      end
      qtail[qa] <= s_r;
    end
    if (pull_en && (head_q != tail_q)) qhead[qa] <= link_h;
  end

  // segment memory, registered read
  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_start_m[wa] <= w_start;
      seg_size_m[wa]  <= w_size;
      seg_owner_m[wa] <= w_owner;
    end
    if (seg_re) begin
      rd_start_r <= seg_start_m[ra];
      rd_size_r  <= seg_size_m[ra];
      rd_owner_r <= seg_owner_m[ra];
      rd_def_r   <= (ra == '0) && e0def_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/priority_scheduler_first_fit_memory_top.sv
// Channel  Handshake            Payload
// in       in_valid/in_stall    in_op, in_priority_req, in_req_size, in_device
// out      out_valid/out_stall  out_ok, out_status, out_pid, out_running_pid,
//                               out_alloc_start
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One command at a time: in_stall stays high from acceptance until the result
// is issued. An arrival scans the segments for the first fit and, on a split,
// moves the later segments up one place. Terminate frees the running process's
// segments in a merge pass. The next command is taken while a result waits on
// out_stall. No clearing pass after reset.
module priority_scheduler_first_fit_memory_top import psff_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [2:0]  in_priority_req,
  input  logic [31:0] in_req_size,
  input  logic [2:0]  in_device,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [2:0]  out_status,
  output logic [15:0] out_pid,
  output logic [15:0] out_running_pid,
  output logic [31:0] out_alloc_start,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  psff_cmd_t  cmd;
  psff_stat_t stat;

  assign cfg_ready = 1'b1;

  psff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  psff_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_op),
    .in_priority_req (in_priority_req),
    .in_req_size     (in_req_size),
    .in_device       (in_device),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_status      (out_status),
    .out_pid         (out_pid),
    .out_running_pid (out_running_pid),
    .out_alloc_start (out_alloc_start)
  );

endmodule

### verif/sched_checker.sv
module sched_checker import psff_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [2:0]  in_priority_req,
  input  logic [31:0] in_req_size,
  input  logic [2:0]  in_device,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_ok,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_pid,
  input  logic [15:0] out_running_pid,
  input  logic [31:0] out_alloc_start,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        ok;
    logic [2:0]  status;
    logic [15:0] pid;
    logic [15:0] run_pid;
    logic [31:0] start;
  } verdict_t;

  verdict_t verdicts[$];

  logic [3:0]  n_prn, n_disk;
  logic [15:0] p_pid[MAX_PROCS];
  logic [2:0]  p_lvl[MAX_PROCS];
  logic        p_live[MAX_PROCS];
  logic [4:0]  p_next[MAX_PROCS];
  logic [4:0]  q_hd[QUEUES], q_tl[QUEUES];
  logic        q_ne[QUEUES];
  logic [4:0]  run_slot;
  logic        busy;
  logic [15:0] pid_ctr;
  logic [31:0] s_start[MAX_SEGMENTS], s_size[MAX_SEGMENTS];
  logic [15:0] s_own[MAX_SEGMENTS];
  int          s_cnt;

  assign pending = verdicts.size();

  function automatic void enqueue(int q, logic [4:0] s);
    if (q_ne[q]) begin
      p_next[q_tl[q]] = s;
      q_tl[q] = s;
    end else begin
      q_hd[q] = s;
      q_tl[q] = s;
      q_ne[q] = 1'b1;
    end
  endfunction

  function automatic logic [4:0] dequeue(int q);
    logic [4:0] s;
    s = q_hd[q];
    if (q_hd[q] == q_tl[q]) q_ne[q] = 1'b0;
    else q_hd[q] = p_next[s];
    return s;
  endfunction

  function automatic void dispatch();
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (q_ne[lv]) begin
        run_slot = dequeue(lv);
        busy = 1'b1;
        return;
      end
    end
    busy = 1'b0;
    run_slot = '0;
  endfunction

  function automatic void make_ready(logic [4:0] s);
    enqueue(p_lvl[s], s);
    if (!busy) dispatch();
  endfunction

  function automatic void coalesce();
    int w;
    w = 0;
    for (int r = 0; r < s_cnt; r++) begin
      if (w > 0 && s_own[w-1] == 0 && s_own[r] == 0) begin
        s_size[w-1] += s_size[r];
      end else begin
        s_start[w] = s_start[r];
        s_size[w] = s_size[r];
        s_own[w] = s_own[r];
        w++;
      end
    end
    s_cnt = w;
  endfunction

  function automatic verdict_t schedule(logic [2:0] op, logic [2:0] prio,
                                        logic [31:0] size, logic [2:0] dev);
    verdict_t v;
    logic [2:0] st;
    logic [15:0] pid;
    logic [31:0] start;
    int slot, seg, lim, q;
    logic is_prn;
    logic [4:0] s;
    st = ST_OK;
    pid = '0;
    start = '0;
    case (op)
      OP_ARRIVE: begin
        if (prio >= LEVELS) begin
          st = ST_BAD_PRIO;
        end else begin
          pid_ctr = pid_ctr + 16'd1;
          if (pid_ctr == 0) pid_ctr = 16'd1;
          slot = MAX_PROCS;
          seg = s_cnt;
          for (int i = 0; i < MAX_PROCS; i++)
            if (!p_live[i]) begin slot = i; break; end
          for (int i = 0; i < s_cnt; i++)
            if (s_own[i] == 0 && s_size[i] >= size) begin seg = i; break; end
          if (slot == MAX_PROCS) st = ST_FULL;
          else if (seg == s_cnt) st = ST_NO_MEM;
          else if (s_size[seg] > size && s_cnt >= MAX_SEGMENTS) st = ST_FULL;
          else begin
            if (s_size[seg] > size) begin
              for (int i = s_cnt; i > seg + 1; i--) begin
                s_start[i] = s_start[i-1];
                s_size[i] = s_size[i-1];
                s_own[i] = s_own[i-1];
              end
              s_start[seg+1] = s_start[seg] + size;
              s_size[seg+1] = s_size[seg] - size;
              s_own[seg+1] = '0;
              s_size[seg] = size;
              s_cnt++;
            end
            s_own[seg] = pid_ctr;
            start = s_start[seg];
            p_live[slot] = 1'b1;
            p_pid[slot] = pid_ctr;
            p_lvl[slot] = prio;
            p_next[slot] = '0;
            pid = pid_ctr;
            make_ready(slot[4:0]);
          end
        end
      end
      OP_TERM: begin
        if (!busy) st = ST_CPU_IDLE;
        else begin
          s = run_slot;
          pid = p_pid[s];
          for (int i = 0; i < s_cnt; i++) if (s_own[i] == pid) s_own[i] = '0;
          coalesce();
          p_live[s] = 1'b0;
          dispatch();
        end
      end
      OP_REQ_DISK, OP_REQ_PRN, OP_FIN_DISK, OP_FIN_PRN: begin
        is_prn = (op == OP_REQ_PRN || op == OP_FIN_PRN);
        lim = is_prn ? n_prn : n_disk;
        if (lim > MAX_DEVICES) lim = MAX_DEVICES;
        q = LEVELS + (is_prn ? MAX_DEVICES : 0) + dev;
        if (dev >= lim) st = ST_BAD_DEV;
        else if (op == OP_REQ_DISK || op == OP_REQ_PRN) begin
          if (!busy) st = ST_CPU_IDLE;
          else begin
            s = run_slot;
            pid = p_pid[s];
            dispatch();
            enqueue(q, s);
          end
        end else if (!q_ne[q]) st = ST_Q_EMPTY;
        else begin
          s = dequeue(q);
          pid = p_pid[s];
          make_ready(s);
        end
      end
      default: st = ST_BAD_DEV;
    endcase
    v.ok = (st == ST_OK);
    v.status = st;
    v.pid = pid;
    v.run_pid = busy ? p_pid[run_slot] : 16'd0;
    v.start = start;
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst_n) begin
      n_prn <= DEV_COUNT_RESET;
      n_disk <= DEV_COUNT_RESET;
      for (int i = 0; i < MAX_PROCS; i++) begin
        p_live[i] = 1'b0; p_pid[i] = '0; p_lvl[i] = '0; p_next[i] = '0;
      end
      for (int i = 0; i < QUEUES; i++) begin
        q_ne[i] = 1'b0; q_hd[i] = '0; q_tl[i] = '0;
      end
      run_slot = '0;
      busy = 1'b0;
      pid_ctr = '0;
      s_start[0] = '0; s_size[0] = MEM_BYTES_RESET; s_own[0] = '0;
      s_cnt = 1;
      verdicts.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MEM_BYTES: begin
            s_start[0] = '0; s_size[0] = cfg_data; s_own[0] = '0;
            s_cnt = 1;
          end
          CFG_PRINTERS: n_prn <= cfg_data[3:0];
          CFG_DISKS: n_disk <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (verdicts.size() == 0) begin
          $display("%0t: unexpected result ok=%0b status=%0d pid=%0d", $realtime,
                   out_ok, out_status, out_pid);
          fail_count <= fail_count + 1;
        end else begin
          exp_v = verdicts.pop_front();
          if ({out_ok, out_status, out_pid, out_running_pid, out_alloc_start} !== exp_v)
          begin
            $display("%0t: mismatch expected ok=%0b st=%0d pid=%0d run=%0d start=%0h",
                     $realtime, exp_v.ok, exp_v.status, exp_v.pid, exp_v.run_pid,
                     exp_v.start);
            $display("%0t:          actual ok=%0b st=%0d pid=%0d run=%0d start=%0h",
                     $realtime, out_ok, out_status, out_pid, out_running_pid,
                     out_alloc_start);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        verdicts.push_back(schedule(in_op, in_priority_req, in_req_size, in_device));
    end
  end
endmodule

### verif/tb.sv
module tb import psff_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = '0;
  logic [2:0]  in_priority_req = '0;
  logic [31:0] in_req_size = '0;
  logic [2:0]  in_device = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok;
  logic [2:0]  out_status;
  logic [15:0] out_pid, out_running_pid;
  logic [31:0] out_alloc_start;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count, pending;
  logic        calm = 1'b0;
  logic        hold_off = 1'b0;
  int          cycles = 0;

  always #10 clk = ~clk;

  priority_scheduler_first_fit_memory_top dut (.*);
  sched_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stalls in bursts; a long hold-off is requested separately
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) out_stall <= 1'b1;
      else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else out_stall <= 1'b0;
    end
  end

  task automatic send(logic [2:0] op, logic [2:0] prio, logic [31:0] size,
                      logic [2:0] dev);
    in_valid <= 1'b1;
    in_op <= op;
    in_priority_req <= prio;
    in_req_size <= size;
    in_device <= dev;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed traffic: arrivals keep memory and the table busy
  task automatic random_cmd(int mem_hint);
    logic [2:0] op;
    logic [31:0] size;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) op = OP_ARRIVE;
    else if (r < 48) op = OP_TERM;
    else if (r < 62) op = OP_REQ_DISK;
    else if (r < 74) op = OP_REQ_PRN;
    else if (r < 86) op = OP_FIN_DISK;
    else if (r < 97) op = OP_FIN_PRN;
    else op = 3'($urandom_range(6, 7));
    r = $urandom_range(0, 19);
    if (r == 0) size = $urandom();
    else if (r == 1) size = 0;
    else size = $urandom_range(1, mem_hint);
    send(op, ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4)),
         size, ($urandom_range(0, 3) == 0) ? 3'($urandom()) : 3'($urandom_range(0, 2)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: idle cpu, empty queues, bad codes, extremes
    send(OP_TERM, 0, 0, 0);
    send(OP_REQ_DISK, 0, 0, 0);
    send(OP_FIN_PRN, 0, 0, 0);
    send(OP_FIN_DISK, 0, 0, 1);
    send(3'd6, 7, 32'hFFFF_FFFF, 7);
    send(3'd7, 0, 0, 0);
    send(OP_ARRIVE, 5, 10, 0);
    send(OP_ARRIVE, 7, 10, 0);
    send(OP_ARRIVE, 0, 32'hFFFF_FFFF, 0);
    send(OP_ARRIVE, 0, 0, 0);
    send(OP_ARRIVE, 4, 100, 0);
    send(OP_ARRIVE, 2, 65536 - 100, 0);
    send(OP_ARRIVE, 1, 1, 0);
    send(OP_REQ_DISK, 0, 0, 0);
    send(OP_REQ_PRN, 0, 0, 0);
    send(OP_REQ_PRN, 0, 0, 7);
    send(OP_FIN_DISK, 0, 0, 0);
    send(OP_FIN_PRN, 0, 0, 0);
    send(OP_TERM, 0, 0, 0);
    send(OP_TERM, 0, 0, 0);
    send(OP_TERM, 0, 0, 0);
    send(OP_TERM, 0, 0, 0);
    settle();
    write_reg(CFG_PRINTERS, 8);
    write_reg(CFG_DISKS, 0);
    write_reg(CFG_MEM_BYTES, 32'hFFFF_FFFF);
    send(OP_REQ_DISK, 0, 0, 0);
    send(OP_ARRIVE, 3, 32'hFFFF_FFFF, 0);
    send(OP_REQ_PRN, 0, 0, 7);
    send(OP_FIN_PRN, 0, 0, 7);
    // tiny arrivals, two more than there are process slots, against memory already taken in full
    for (int i = 0; i < MAX_PROCS + 2; i++) send(OP_ARRIVE, 3'(i % 5), 1, 0);
    // pressure: receiver holds off while commands keep coming
    hold_off <= 1'b1;
    fork
      begin
        for (int i = 0; i < 10; i++) send(OP_REQ_PRN, 0, 0, 3'(i % 8));
      end
      begin
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
    join
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_MEM_BYTES, 1);
          write_reg(CFG_PRINTERS, 0);
          write_reg(CFG_DISKS, 8);
        end
        1: begin
          write_reg(CFG_MEM_BYTES, 4096);
          write_reg(CFG_PRINTERS, 15);
          write_reg(CFG_DISKS, 15);
        end
        2: begin
          write_reg(CFG_MEM_BYTES, 65536);
          write_reg(CFG_PRINTERS, 3);
          write_reg(CFG_DISKS, 3);
        end
        default: begin
          write_reg(CFG_MEM_BYTES, 2000);
          write_reg(CFG_PRINTERS, 1);
          write_reg(CFG_DISKS, 2);
        end
      endcase
      if (ph == 3) calm <= 1'b1;
      for (int i = 0; i < 480; i++)
        random_cmd(ph == 1 ? 200 : (ph == 2 ? 3000 : 80));
    end
    settle();
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
